[src/per_bin_running_mean_variance_unit_defines.svh]
// assertion macros used by the port-level checker file
`ifndef PER_BIN_RUNNING_MEAN_VARIANCE_UNIT_DEFINES_SVH
`define PER_BIN_RUNNING_MEAN_VARIANCE_UNIT_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define PBRMV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define PBRMV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/pbrmv_pkg.sv]
// types and constants of the per-bin running statistics unit
package pbrmv_pkg;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATIONS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b1;
    localparam logic [15:0] ITERATIONS_RST = 16'd1000;
    localparam logic [15:0] THRESHOLD_RST  = 16'd0;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;
    localparam logic [STEP_W-1:0] SQRT_LAST = 6'd31;
    localparam logic [STEP_W-1:0] MUL_LAST  = 6'd2;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  bin_index;
        logic [31:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  echo_index;
        logic [15:0] occurrences;
        logic [31:0] mean_value;
        logic [31:0] std_dev;
        logic        std_valid;
        logic        selected;
    } t_out_item;

    typedef struct packed {
        logic [15:0] count;
        logic [47:0] mean;
        logic [63:0] sq_dev;
    } t_bin;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_DIVM,
        S_UPD,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_WRITE,
        S_STAT,
        S_DIVV,
        S_SQL,
        S_SQRT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       clr_wr;
        logic       capture;
        logic       load;
        logic       set_first;
        logic       div_mean_start;
        logic       div_step;
        logic       mean_upd;
        logic       calc_e;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       m2_upd;
        logic       wr;
        logic       div_var_start;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       out_fire;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic do_update;
        logic first;
        logic count_ge2;
    } t_dp_sts;

endpackage

[src/per_bin_running_mean_variance_unit.sv]
// top level of the per-bin running mean and variance unit
//
//  channel   signals                               transfer
//  --------  ------------------------------------  ------------------------------
//  item in   start, busy, i_item                   start high while busy low
//  result    o_valid, o_result                     one-cycle strobe, no backpressure
//  config    i_cfg_we, i_cfg_idx, i_cfg_data       write enable, no wait
//
// an add to a bin already holding a sample and a read of a bin with two or more samples
// keep busy high through the 64-step shared divider and 32-step sqrt; such adds also
// run a three-step 16x48 multiply; a first add and any other command skip all of these.
// the result strobe comes in the first idle cycle, where a new beat can already be taken.
// after reset the bin store is cleared one entry a cycle, with busy high.
// a result is presented for one cycle; the receiver cannot stall it.
module per_bin_running_mean_variance_unit #(
    parameter int NUM_BINS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pbrmv_pkg::t_in_item             i_item,
    input  logic                            i_cfg_we,
    input  logic [pbrmv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                     i_cfg_data,
    output logic                            o_valid,
    output pbrmv_pkg::t_out_item            o_result
);
    import pbrmv_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    pbrmv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // datapath and bin store
    pbrmv_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result),
        .o_valid    (o_valid)
    );

endmodule

[src/pbrmv_ctrl.sv]
// sequencer of the per-bin statistics unit
module pbrmv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pbrmv_pkg::t_dp_sts i_sts,
    output pbrmv_pkg::t_dp_cmd o_cmd,
    output logic               o_busy
);
    import pbrmv_pkg::*;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign n_step = (n_state != r_state) ? '0 : r_step + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:   if (i_start) n_state = S_READ;
            S_READ:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (!i_sts.do_update) n_state = S_STAT;
                else if (i_sts.first) n_state = S_WRITE;
                else n_state = S_DIVM;
            end
            S_DIVM:   if (r_step == DIV_LAST) n_state = S_UPD;
            S_UPD:    n_state = S_DIFF;
            S_DIFF:   n_state = S_MUL;
            S_MUL:    if (r_step == MUL_LAST) n_state = S_ACC;
            S_ACC:    n_state = S_WRITE;
            S_WRITE:  n_state = S_STAT;
            S_STAT:   n_state = i_sts.count_ge2 ? S_DIVV : S_OUT;
            S_DIVV:   if (r_step == DIV_LAST) n_state = S_SQL;
            S_SQL:    n_state = S_SQRT;
            S_SQRT:   if (r_step == SQRT_LAST) n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        o_cmd.mul_sel = r_step[1:0];
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_wr = 1'b1;
            S_IDLE:   o_cmd.capture = i_start;
            S_READ:   o_cmd.load = 1'b1;
            S_DECIDE: begin
                o_cmd.set_first      = i_sts.do_update & i_sts.first;
                o_cmd.div_mean_start = i_sts.do_update & ~i_sts.first;
            end
            S_DIVM:   o_cmd.div_step = 1'b1;
            S_UPD:    o_cmd.mean_upd = 1'b1;
            S_DIFF:   o_cmd.calc_e = 1'b1;
            S_MUL:    o_cmd.mul_step = 1'b1;
            S_ACC:    o_cmd.m2_upd = 1'b1;
            S_WRITE:  o_cmd.wr = 1'b1;
            S_STAT:   o_cmd.div_var_start = i_sts.count_ge2;
            S_DIVV:   o_cmd.div_step = 1'b1;
            S_SQL:    o_cmd.sqrt_load = 1'b1;
            S_SQRT:   o_cmd.sqrt_step = 1'b1;
            S_OUT:    o_cmd.out_fire = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[src/pbrmv_datapath.sv]
// bin store, shared divider, multiplier, square root and result register
module pbrmv_datapath #(
    parameter int NUM_BINS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pbrmv_pkg::t_dp_cmd             i_cmd,
    output pbrmv_pkg::t_dp_sts             o_sts,
    input  pbrmv_pkg::t_in_item            i_item,
    input  logic                           i_cfg_we,
    input  logic [pbrmv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                    i_cfg_data,
    output pbrmv_pkg::t_out_item           o_result,
    output logic                           o_valid
);
    import pbrmv_pkg::*;

    localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    t_bin mem [NUM_BINS];
    t_bin r_rd;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_addr;
    logic [9:0]        r_idx;
    logic              r_in_range, r_is_add, r_upd, r_xge;
    logic [47:0]       r_x, r_mean, r_d, r_e;
    logic [15:0]       r_cnt;
    logic [63:0]       r_m2;
    logic [63:0]       r_div;
    logic [15:0]       r_rem, r_dvsr;
    logic [95:0]       r_acc;
    logic [63:0]       r_sq_rad;
    logic [35:0]       r_sq_rem;
    logic [31:0]       r_sq_root;
    logic [15:0]       r_iter, r_tf;
    logic [31:0]       r_thr;

    logic [16:0] in_idx;
    logic [ADDR_W-1:0] in_addr;
    logic        in_range;
    logic [47:0] diff;
    logic [16:0] rem_sh;
    logic        div_ge;
    logic [15:0] mul_a;
    logic [63:0] part;
    logic [95:0] part_sh;
    logic [64:0] m2_sum;
    logic [35:0] sq_sh, sq_trial;
    logic        sq_ge;

    assign in_idx   = {7'b0, i_item.bin_index};
    assign in_addr  = in_idx[ADDR_W-1:0];
    assign in_range = (in_idx < 17'(NUM_BINS));

    // status toward the sequencer
    assign o_sts.clr_last  = (r_clr_addr == ADDR_W'(NUM_BINS - 1));
    assign o_sts.do_update = r_upd;
    assign o_sts.first     = (r_cnt == 16'd1);
    assign o_sts.count_ge2 = (r_cnt >= 16'd2);

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // bin store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr) begin
            mem[r_addr] <= '{count: r_cnt, mean: r_mean, sq_dev: r_m2};
        end
        if (i_cmd.capture) begin
            r_rd <= mem[in_addr];
        end
    end

    // configuration registers and selection threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= ITERATIONS_RST;
            r_tf   <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ITERATIONS: r_iter <= i_cfg_data;
                CFG_THRESHOLD:  r_tf   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr <= 32'(r_iter) * 32'(r_tf);
    end

    // divider: one quotient bit a beat
    assign rem_sh = {r_rem, r_div[63]};
    assign div_ge = (rem_sh >= {1'b0, r_dvsr});

    // multiplier: 16 bits of d against e per beat
    always_comb begin
        case (i_cmd.mul_sel)
            2'd0:    mul_a = r_d[15:0];
            2'd1:    mul_a = r_d[31:16];
            default: mul_a = r_d[47:32];
        endcase
    end
    assign part = 64'(mul_a) * 64'(r_e);
    always_comb begin
        case (i_cmd.mul_sel)
            2'd0:    part_sh = {32'b0, part};
            2'd1:    part_sh = {16'b0, part, 16'b0};
            default: part_sh = {part, 32'b0};
        endcase
    end

    assign m2_sum = {1'b0, r_m2} + {1'b0, r_acc[95:32]};
    assign diff   = (r_x >= r_mean) ? (r_x - r_mean) : (r_mean - r_x);

    // square root: two radicand bits a beat
    assign sq_sh    = {r_sq_rem[33:0], r_sq_rad[63:62]};
    assign sq_trial = {2'b0, r_sq_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr     <= in_addr;
            r_idx      <= i_item.bin_index;
            r_in_range <= in_range;
            r_is_add   <= (i_item.cmd == CMD_ADD);
            r_x        <= {i_item.sample_value, 16'b0};
        end
        if (i_cmd.load) begin
            r_upd <= r_is_add & r_in_range;
            if (!r_in_range) begin
                r_cnt  <= '0;
                r_mean <= '0;
                r_m2   <= '0;
            end else begin
                r_cnt  <= (r_is_add && r_rd.count != COUNT_MAX) ?
                          r_rd.count + 1'b1 : r_rd.count;
                r_mean <= r_rd.mean;
                r_m2   <= r_rd.sq_dev;
            end
        end
        if (i_cmd.set_first) begin
            r_mean <= r_x;
        end
        if (i_cmd.div_mean_start) begin
            r_d    <= diff;
            r_xge  <= (r_x >= r_mean);
            r_div  <= {16'b0, diff};
            r_rem  <= '0;
            r_dvsr <= r_cnt;
        end
        if (i_cmd.div_var_start) begin
            r_div  <= r_m2;
            r_rem  <= '0;
            r_dvsr <= r_cnt - 1'b1;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? 16'(rem_sh - {1'b0, r_dvsr}) : rem_sh[15:0];
            r_div <= {r_div[62:0], div_ge};
        end
        if (i_cmd.mean_upd) begin
            r_mean <= r_xge ? (r_mean + r_div[47:0]) : (r_mean - r_div[47:0]);
        end
        if (i_cmd.calc_e) begin
            r_e   <= diff;
            r_acc <= '0;
        end
        if (i_cmd.mul_step) begin
            r_acc <= r_acc + part_sh;
        end
        if (i_cmd.m2_upd) begin
            r_m2 <= m2_sum[64] ? '1 : m2_sum[63:0];
        end
        if (i_cmd.sqrt_load) begin
            r_sq_rad  <= r_div;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_sq_rad  <= {r_sq_rad[61:0], 2'b00};
            r_sq_rem  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
            r_sq_root <= {r_sq_root[30:0], sq_ge};
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_fire) begin
            o_result.echo_index  <= r_idx;
            o_result.occurrences <= r_cnt;
            o_result.mean_value  <= r_mean[47:16];
            o_result.std_dev     <= (r_cnt >= 16'd2) ? r_sq_root : '0;
            o_result.std_valid   <= (r_cnt >= 16'd2);
            o_result.selected    <= ({r_cnt, 16'b0} >= r_thr);
        end
    end

endmodule

[src/pbrmv_checker.sv]
// port-level checks of the per-bin statistics unit and their binding
`include "per_bin_running_mean_variance_unit_defines.svh"

module pbrmv_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input pbrmv_pkg::t_out_item o_result
);
    import pbrmv_pkg::*;

    // an accepted beat keeps the unit busy
    `PBRMV_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")

    // results appear only once the unit is free again
    `PBRMV_ASSERT(a_valid_idle, o_valid |-> !busy, "result strobe while busy")

    // one strobe per item
    `PBRMV_ASSERT(a_single_beat, o_valid |=> !o_valid, "result strobe held two cycles")

    // a deviation is reported only for bins with two or more samples
    `PBRMV_ASSERT(a_std_rule,
        o_valid |-> ((o_result.std_valid == (o_result.occurrences >= 16'd2)) &&
                     (o_result.std_valid || o_result.std_dev == 32'd0)),
        "std_valid or std_dev inconsistent with count")

    // no strobe out of reset
    `PBRMV_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_valid, "result strobe after reset")

endmodule

bind per_bin_running_mean_variance_unit pbrmv_checker u_pbrmv_checker (.*);

[tb/per_bin_running_mean_variance_unit_checker.sv]
// result checker for the per-bin running statistics unit: tracks bins, predicts and compares
`timescale 1ns / 100ps

module per_bin_running_mean_variance_unit_checker #(
    parameter int NUM_BINS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  pbrmv_pkg::t_in_item             i_item,
    input  logic                            i_cfg_we,
    input  logic [pbrmv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            i_valid,
    input  pbrmv_pkg::t_out_item            i_result,
    output int                              o_fail_count,
    output int                              o_pending
);
    import pbrmv_pkg::*;

    // shadow copy of the bin store and registers
    logic [15:0] shadow_count [NUM_BINS];
    logic [47:0] shadow_mean  [NUM_BINS];
    logic [63:0] shadow_sq_dev[NUM_BINS];
    logic [15:0] shadow_iterations;
    logic [15:0] shadow_threshold;

    t_out_item stats_queue[$];

    assign o_pending = stats_queue.size();

    // floor square root, two bits per step
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem, root, one_bit;
        rem = v;
        root = '0;
        one_bit = 64'h4000_0000_0000_0000;
        while (one_bit > v) one_bit = one_bit >> 2;
        while (one_bit != 0) begin
            if (rem >= root + one_bit) begin
                rem = rem - (root + one_bit);
                root = (root >> 1) + one_bit;
            end else begin
                root = root >> 1;
            end
            one_bit = one_bit >> 2;
        end
        return root;
    endfunction

    // welford update of one bin on an add, then the statistics of that bin
    task automatic run_bin_command(input t_in_item it, output t_out_item res);
        logic [63:0] x, mu, d, e, n, cnt, m2;
        logic [95:0] prod;
        logic [64:0] acc;
        logic [31:0] lhs, rhs;
        int unsigned idx;
        idx = it.bin_index;
        cnt = 0;
        mu = 0;
        m2 = 0;
        if (idx < NUM_BINS) begin
            if (it.cmd == CMD_ADD) begin
                x = {16'b0, it.sample_value, 16'b0};
                n = shadow_count[idx];
                if (n < COUNT_MAX) n = n + 1;
                shadow_count[idx] = n[15:0];
                mu = shadow_mean[idx];
                if (n == 1) begin
                    shadow_mean[idx] = x[47:0];
                end else begin
                    if (x >= mu) begin
                        d = x - mu;
                        mu = mu + d / n;
                        e = x - mu;
                    end else begin
                        d = mu - x;
                        mu = mu - d / n;
                        e = mu - x;
                    end
                    shadow_mean[idx] = mu[47:0];
                    prod = 96'(d) * 96'(e);
                    acc = 65'(shadow_sq_dev[idx]) + 65'(prod[95:32]);
                    shadow_sq_dev[idx] = acc[64] ? '1 : acc[63:0];
                end
            end
            cnt = shadow_count[idx];
            mu = shadow_mean[idx];
            m2 = shadow_sq_dev[idx];
        end
        res.echo_index = it.bin_index;
        res.occurrences = cnt[15:0];
        res.mean_value = mu[47:16];
        res.std_valid = (cnt >= 2);
        res.std_dev = (cnt >= 2) ? 32'(floor_sqrt(m2 / (cnt - 1))) : '0;
        lhs = {cnt[15:0], 16'b0};
        rhs = 32'(shadow_threshold) * 32'(shadow_iterations);
        res.selected = (lhs >= rhs);
    endtask

    // field compare against the oldest expectation
    task automatic compare_result(input t_out_item exp_r, input t_out_item got);
        if (got.echo_index !== exp_r.echo_index) begin
            $error("echo_index: expected %0d, got %0d", exp_r.echo_index, got.echo_index);
            o_fail_count++;
        end
        if (got.occurrences !== exp_r.occurrences) begin
            $error("occurrences: expected %0d, got %0d", exp_r.occurrences, got.occurrences);
            o_fail_count++;
        end
        if (got.mean_value !== exp_r.mean_value) begin
            $error("mean_value: expected %h, got %h", exp_r.mean_value, got.mean_value);
            o_fail_count++;
        end
        if (got.std_dev !== exp_r.std_dev) begin
            $error("std_dev: expected %h, got %h", exp_r.std_dev, got.std_dev);
            o_fail_count++;
        end
        if (got.std_valid !== exp_r.std_valid) begin
            $error("std_valid: expected %b, got %b", exp_r.std_valid, got.std_valid);
            o_fail_count++;
        end
        if (got.selected !== exp_r.selected) begin
            $error("selected: expected %b, got %b", exp_r.selected, got.selected);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    // watch config writes, accepted commands and result beats
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            shadow_iterations <= ITERATIONS_RST;
            shadow_threshold <= THRESHOLD_RST;
            for (int i = 0; i < NUM_BINS; i++) begin
                shadow_count[i] = '0;
                shadow_mean[i] = '0;
                shadow_sq_dev[i] = '0;
            end
            stats_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ITERATIONS) shadow_iterations <= i_cfg_data;
                else if (i_cfg_idx == CFG_THRESHOLD) shadow_threshold <= i_cfg_data;
            end
            if (i_valid) begin
                if (stats_queue.size() == 0) begin
                    $error("result beat for bin %0d with no command outstanding",
                           i_result.echo_index);
                    o_fail_count++;
                end else begin
                    compare_result(stats_queue.pop_front(), i_result);
                end
            end
            if (i_start && !i_busy) begin
                run_bin_command(i_item, exp_r);
                stats_queue = {stats_queue, exp_r};
            end
        end
    end

endmodule

[tb/per_bin_running_mean_variance_unit_tb.sv]
// stimulus and verdict for the per-bin running statistics unit
`timescale 1ns / 100ps

module per_bin_running_mean_variance_unit_tb;
    import pbrmv_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 200;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in_item i_item;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic o_valid;
    t_out_item o_result;
    int fail_count;
    int pending;
    int cycle_count;

    logic [9:0] hot_bin[8];
    logic [31:0] hot_base[8];
    logic [15:0] phase_iterations[PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd1000, 16'd65535,
                                             16'd200};
    logic [15:0] phase_threshold[PHASES] = '{16'd65535, 16'd65535, 16'd40000, 16'd3000,
                                            16'd0, 16'd65535};

    per_bin_running_mean_variance_unit #(.NUM_BINS(1024)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_result(o_result)
    );

    per_bin_running_mean_variance_unit_checker #(.NUM_BINS(1024)) stats_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_item(i_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_result(o_result), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** per_bin_running_mean_variance_unit: FAILED **");
            $finish;
        end
    end

    // hand one command over, start stays high for the caller to lower
    task automatic send_command(input logic cmd, input logic [9:0] idx,
                                input logic [31:0] value);
        start <= 1'b1;
        i_item <= '{cmd: cmd, bin_index: idx, sample_value: value};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait until the unit is idle and every result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random sample value: near the bin's own level, fully random, all ones or zero, or small
    function automatic logic [31:0] pick_value(input int h);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return hot_base[h] + $urandom_range(0, 4096) - 2048;
        if (sel < 70) return $urandom;
        if (sel < 85) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom_range(0, 255);
    endfunction

    // start is left high after the last beat for the caller to lower
    task automatic random_commands(input int count);
        int burst, h;
        logic [9:0] idx;
        logic [31:0] value;
        burst = $urandom_range(1, 30);
        for (int k = 0; k < count; k++) begin
            h = $urandom_range(0, 7);
            if ($urandom_range(0, 99) < 85) begin
                idx = hot_bin[h];
            end else begin
                idx = $urandom_range(0, 1023);
            end
            value = pick_value(h);
            send_command(($urandom_range(0, 99) < 30) ? CMD_READ : CMD_ADD, idx, value);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                idle_cycles(($urandom_range(0, 1) != 0) ? $urandom_range(0, 5)
                                                        : $urandom_range(1, 250));
            end
        end
    endtask

    initial begin
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ITERATIONS;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        for (int h = 0; h < 8; h++) begin
            hot_bin[h] = $urandom_range(0, 1023);
            hot_base[h] = $urandom;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty bins, first sample, extreme values, top and bottom bins
        drain_results();
        send_command(CMD_READ, 10'd0, 32'h0);
        send_command(CMD_ADD, 10'd0, 32'h0);
        send_command(CMD_READ, 10'd0, 32'h0);
        send_command(CMD_ADD, 10'd0, 32'hFFFF_FFFF);
        send_command(CMD_ADD, 10'd0, 32'h0);
        send_command(CMD_ADD, 10'd0, 32'hFFFF_FFFF);
        send_command(CMD_READ, 10'd1023, 32'hFFFF_FFFF);
        send_command(CMD_ADD, 10'd1023, 32'hFFFF_FFFF);
        send_command(CMD_ADD, 10'd1023, 32'hFFFF_FFFF);
        send_command(CMD_READ, 10'd1023, 32'h0);
        send_command(CMD_ADD, 10'd5, 32'h0001_0000);
        send_command(CMD_ADD, 10'd5, 32'h0002_0000);
        send_command(CMD_ADD, 10'd5, 32'h0003_0000);
        send_command(CMD_ADD, 10'd2, 32'h8000_0000);
        send_command(CMD_ADD, 10'd2, 32'h7FFF_FFFF);
        send_command(CMD_ADD, 10'd2, 32'h0000_0001);
        send_command(CMD_READ, 10'd2, 32'h0);
        send_command(CMD_ADD, 10'd512, 32'h5555_AAAA);
        send_command(CMD_ADD, 10'd512, 32'hAAAA_5555);
        send_command(CMD_READ, 10'd512, 32'h0);

        // each phase under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_register(CFG_ITERATIONS, phase_iterations[p]);
            write_register(CFG_THRESHOLD, phase_threshold[p]);
            random_commands(ITEMS_PER_PHASE / 2);
            // hold off until every outstanding result is back
            start <= 1'b0;
            @(posedge i_clk);
            while (busy || pending != 0) @(posedge i_clk);
            random_commands(ITEMS_PER_PHASE / 2);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (busy || pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** per_bin_running_mean_variance_unit: PASSED **");
        end else begin
            $display("** per_bin_running_mean_variance_unit: FAILED **");
        end
        $finish;
    end

endmodule

[per_bin_running_mean_variance_unit.f]
+incdir+src
src/pbrmv_pkg.sv
src/pbrmv_ctrl.sv
src/pbrmv_datapath.sv
src/per_bin_running_mean_variance_unit.sv
src/pbrmv_checker.sv
tb/per_bin_running_mean_variance_unit_checker.sv
tb/per_bin_running_mean_variance_unit_tb.sv
